>>> hw/rtl/mqe_pkg.sv
// Package for the MQ arithmetic encoder: mode and command codes, status
// and command structs, the Qe probability table and the byte-out step.
// No dependencies.
package mqe_pkg;

   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_INIT    = 4'd1,
      OP_CLEAR   = 4'd2,
      OP_LOAD    = 4'd3,
      OP_CODE    = 4'd4,
      OP_RENORM  = 4'd5,
      OP_TPREP   = 4'd6,
      OP_TMOVE   = 4'd7,
      OP_TPEND   = 4'd8,
      OP_TFF     = 4'd9,
      OP_TAC     = 4'd10,
      OP_RELEASE = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      MODE_ENCODE = 2'd0,
      MODE_FLUSH  = 2'd1,
      MODE_START  = 2'd2
   } mode_type;

   typedef struct packed {
      op_type op;
      logic   end_mark;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic a_msb;
      logic need_renorm;
      logic finished;
      logic hold_valid;
   } status_type;

   typedef struct packed {
      logic [27:0] c;
      logic [7:0]  b;
      logic [3:0]  ct;
      logic [7:0]  put_val;
   } mv_type;

   typedef struct packed {
      logic [15:0] q;
      logic [5:0]  nmps;
      logic [5:0]  nlps;
      logic        flip;
   } qrow_type;

   localparam logic [15:0] A_INIT     = 16'h8000;
   localparam logic [3:0]  CT_INIT    = 4'd12;
   localparam logic [7:0]  BYTE_FF    = 8'hFF;
   localparam logic [7:0]  BYTE_AC    = 8'hAC;
   localparam logic [5:0]  IDX_LAST   = 6'd46;

   function automatic qrow_type qe_row(input logic [5:0] idx);
      qrow_type r;
      case (idx)
         6'd0:  r = '{16'h5601, 6'd1,  6'd1,  1'b1};
         6'd1:  r = '{16'h3401, 6'd2,  6'd6,  1'b0};
         6'd2:  r = '{16'h1801, 6'd3,  6'd9,  1'b0};
         6'd3:  r = '{16'h0AC1, 6'd4,  6'd12, 1'b0};
         6'd4:  r = '{16'h0521, 6'd5,  6'd29, 1'b0};
         6'd5:  r = '{16'h0221, 6'd38, 6'd33, 1'b0};
         6'd6:  r = '{16'h5601, 6'd7,  6'd6,  1'b1};
         6'd7:  r = '{16'h5401, 6'd8,  6'd14, 1'b0};
         6'd8:  r = '{16'h4801, 6'd9,  6'd14, 1'b0};
         6'd9:  r = '{16'h3801, 6'd10, 6'd14, 1'b0};
         6'd10: r = '{16'h3001, 6'd11, 6'd17, 1'b0};
         6'd11: r = '{16'h2401, 6'd12, 6'd18, 1'b0};
         6'd12: r = '{16'h1C01, 6'd13, 6'd20, 1'b0};
         6'd13: r = '{16'h1601, 6'd29, 6'd21, 1'b0};
         6'd14: r = '{16'h5601, 6'd15, 6'd14, 1'b1};
         6'd15: r = '{16'h5401, 6'd16, 6'd14, 1'b0};
         6'd16: r = '{16'h5101, 6'd17, 6'd15, 1'b0};
         6'd17: r = '{16'h4801, 6'd18, 6'd16, 1'b0};
         6'd18: r = '{16'h3801, 6'd19, 6'd17, 1'b0};
         6'd19: r = '{16'h3401, 6'd20, 6'd18, 1'b0};
         6'd20: r = '{16'h3001, 6'd21, 6'd19, 1'b0};
         6'd21: r = '{16'h2801, 6'd22, 6'd19, 1'b0};
         6'd22: r = '{16'h2401, 6'd23, 6'd20, 1'b0};
         6'd23: r = '{16'h2201, 6'd24, 6'd21, 1'b0};
         6'd24: r = '{16'h1C01, 6'd25, 6'd22, 1'b0};
         6'd25: r = '{16'h1801, 6'd26, 6'd23, 1'b0};
         6'd26: r = '{16'h1601, 6'd27, 6'd24, 1'b0};
         6'd27: r = '{16'h1401, 6'd28, 6'd25, 1'b0};
         6'd28: r = '{16'h1201, 6'd29, 6'd26, 1'b0};
         6'd29: r = '{16'h1101, 6'd30, 6'd27, 1'b0};
         6'd30: r = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
         6'd31: r = '{16'h09C1, 6'd32, 6'd29, 1'b0};
         6'd32: r = '{16'h08A1, 6'd33, 6'd30, 1'b0};
         6'd33: r = '{16'h0521, 6'd34, 6'd31, 1'b0};
         6'd34: r = '{16'h0441, 6'd35, 6'd32, 1'b0};
         6'd35: r = '{16'h02A1, 6'd36, 6'd33, 1'b0};
         6'd36: r = '{16'h0221, 6'd37, 6'd34, 1'b0};
         6'd37: r = '{16'h0141, 6'd38, 6'd35, 1'b0};
         6'd38: r = '{16'h0111, 6'd39, 6'd36, 1'b0};
         6'd39: r = '{16'h0085, 6'd40, 6'd37, 1'b0};
         6'd40: r = '{16'h0049, 6'd41, 6'd38, 1'b0};
         6'd41: r = '{16'h0025, 6'd42, 6'd39, 1'b0};
         6'd42: r = '{16'h0015, 6'd43, 6'd40, 1'b0};
         6'd43: r = '{16'h0009, 6'd44, 6'd41, 1'b0};
         6'd44: r = '{16'h0005, 6'd45, 6'd42, 1'b0};
         6'd45: r = '{16'h0001, 6'd45, 6'd43, 1'b0};
         default: r = '{16'h5601, 6'd46, 6'd46, 1'b0};
      endcase
      return r;
   endfunction

   // Byte-out step with carry propagation and bit stuffing after 0xFF.
   function automatic mv_type move_byte(input logic [27:0] c, input logic [7:0] b);
      mv_type r;
      logic [7:0] b1;
      b1 = b + 8'd1;
      if (b == BYTE_FF) begin
         r.put_val = b;
         r.b       = c[27:20];
         r.c       = {8'd0, c[19:0]};
         r.ct      = 4'd7;
      end else if (c[27] && (b1 == BYTE_FF)) begin
         r.put_val = BYTE_FF;
         r.b       = {1'b0, c[26:20]};
         r.c       = {8'd0, c[19:0]};
         r.ct      = 4'd7;
      end else begin
         r.put_val = c[27] ? b1 : b;
         r.b       = c[26:19];
         r.c       = {9'd0, c[18:0]};
         r.ct      = 4'd8;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/mq_arithmetic_encoder.sv
// Top level of the JBIG2 MQ arithmetic encoder: controller, datapath and
// context store RAM. Depends on mqe_pkg, mqe_ctrl, mqe_datapath, mqe_ram.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_mode, req_context_number, req_symbol_bit
//   rsp     | out       | rsp_valid, rsp_stall, rsp_code_byte, rsp_last_of_run, rsp_end_marker
//
// An encode word steps through store read, code, the renormalization shifts, the
// renormalization exit and close; a flush word steps through prepare, two byte moves,
// pending byte, 0xFF, 0xAC and close. A byte step waits for as long as the output
// register is stalled. Reset and each start word sweep the context store with req_stall high.
module mq_arithmetic_encoder #(
   parameter int CONTEXT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_context_number,
   input  logic        req_symbol_bit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_end_marker
);
   import mqe_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [CONTEXT_BITS-1:0] clear_addr;
   logic idle;
   logic ram_we;
   logic [CONTEXT_BITS-1:0] ram_waddr, ram_raddr;
   logic [6:0] ram_wdata, ram_rdata;

   mqe_ctrl #(.CONTEXT_BITS(CONTEXT_BITS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_mode,
      .status, .cmd, .clear_addr, .idle
   );

   mqe_datapath #(.CONTEXT_BITS(CONTEXT_BITS)) u_dp (
      .clock, .reset, .cmd, .clear_addr, .status,
      .req_context_number, .req_symbol_bit,
      .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata,
      .rsp_valid, .rsp_stall, .rsp_code_byte, .rsp_last_of_run, .rsp_end_marker
   );

   mqe_ram #(.WIDTH(7), .DEPTH(2 ** CONTEXT_BITS)) u_ctx_ram (
      .clock, .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      idle |-> !status.hold_valid)
      else $error("byte left held between words");
   a_idle_norm: assert property (@(posedge clock) disable iff (reset)
      idle |-> status.a_msb)
      else $error("interval not normalized between words");
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_marker) |-> rsp_last_of_run && rsp_code_byte == BYTE_AC)
      else $error("end marker on wrong word");
endmodule

>>> hw/rtl/mqe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mqe_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/mqe_datapath.sv
// Datapath of the MQ encoder: interval and code registers, byte assembly,
// held byte and output register, context store ports. Depends on mqe_pkg.
module mqe_datapath #(
   parameter int CONTEXT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mqe_pkg::cmd_type         cmd,
   input  logic [CONTEXT_BITS-1:0]  clear_addr,
   output mqe_pkg::status_type      status,
   input  logic [15:0]              req_context_number,
   input  logic                     req_symbol_bit,
   output logic                     ram_we,
   output logic [CONTEXT_BITS-1:0]  ram_waddr,
   output logic [6:0]               ram_wdata,
   output logic [CONTEXT_BITS-1:0]  ram_raddr,
   input  logic [6:0]               ram_rdata,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_code_byte,
   output logic                     rsp_last_of_run,
   output logic                     rsp_end_marker
);
   import mqe_pkg::*;

   logic [15:0] a_ff, a_in;
   logic [27:0] c_ff, c_in;
   logic [3:0]  ct_ff, ct_in;
   logic [7:0]  b_ff, b_in;
   logic        bfirst_ff, bfirst_in;
   logic        fin_ff, fin_in;
   logic        renorm_ff, renorm_in;
   logic [CONTEXT_BITS-1:0] ctx_ff, ctx_in;
   logic        bit_ff, bit_in;
   logic        hold_v_ff, hold_v_in;
   logic [7:0]  hold_ff, hold_in;
   logic        ov_ff, ov_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        olast_ff, olast_in;
   logic        oend_ff, oend_in;

   logic        out_free;
   logic        put;
   logic [7:0]  put_val;
   logic        rel;
   qrow_type    row;
   logic [5:0]  idx;
   logic        mps;
   logic [15:0] a1;
   logic [28:0] top;
   logic [27:0] cf;
   logic [27:0] cs;
   logic [15:0] a2;
   logic [27:0] c2;
   logic [3:0]  ct2;
   mv_type      mv;

   assign out_free = !ov_ff || !rsp_stall;
   assign idx = (ram_rdata[5:0] > IDX_LAST) ? IDX_LAST : ram_rdata[5:0];
   assign mps = ram_rdata[6];
   assign row = qe_row(idx);
   assign a1  = a_ff - row.q;
   assign top = {1'b0, c_ff} + {13'd0, a_ff};
   assign ram_raddr = req_context_number[CONTEXT_BITS-1:0];

   always_comb begin
      a_in = a_ff; c_in = c_ff; ct_in = ct_ff; b_in = b_ff;
      bfirst_in = bfirst_ff; fin_in = fin_ff; renorm_in = renorm_ff;
      ctx_in = ctx_ff; bit_in = bit_ff;
      put = 1'b0; put_val = b_ff; rel = 1'b0;
      ram_we = 1'b0; ram_waddr = ctx_ff; ram_wdata = '0;
      cf = c_ff | 28'h000FFFF;
      cs = '0; a2 = '0; c2 = '0; ct2 = '0;
      mv = move_byte(c_ff, b_ff);
      case (cmd.op)
         OP_INIT: begin
            a_in = A_INIT; c_in = '0; ct_in = CT_INIT; b_in = '0;
            bfirst_in = 1'b1; fin_in = 1'b0;
         end
         OP_CLEAR: begin
            ram_we = 1'b1; ram_waddr = clear_addr;
         end
         OP_LOAD: begin
            ctx_in = req_context_number[CONTEXT_BITS-1:0];
            bit_in = req_symbol_bit;
         end
         OP_CODE: begin
            a_in = a1;
            renorm_in = 1'b1;
            if (bit_ff == mps) begin
               if (!a1[15]) begin
                  if (a1 < row.q) a_in = row.q;
                  else c_in = c_ff + {12'd0, row.q};
                  ram_we = 1'b1; ram_wdata = {mps, row.nmps};
               end else begin
                  c_in = c_ff + {12'd0, row.q};
                  renorm_in = 1'b0;
               end
            end else begin
               if (a1 < row.q) c_in = c_ff + {12'd0, row.q};
               else a_in = row.q;
               ram_we = 1'b1; ram_wdata = {mps ^ row.flip, row.nlps};
            end
         end
         OP_RENORM: begin
            a2 = {a_ff[14:0], 1'b0};
            c2 = {c_ff[26:0], 1'b0};
            ct2 = ct_ff - 4'd1;
            a_in = a2; c_in = c2; ct_in = ct2;
            if (ct2 == 4'd0) begin
               mv = move_byte(c2, b_ff);
               c_in = mv.c; b_in = mv.b; ct_in = mv.ct;
               put = 1'b1; put_val = mv.put_val;
            end
         end
         OP_TPREP: begin
            c_in = ({1'b0, cf} >= top) ? cf - 28'h0008000 : cf;
         end
         OP_TMOVE: begin
            cs = c_ff << ct_ff;
            mv = move_byte(cs, b_ff);
            c_in = mv.c; b_in = mv.b; ct_in = mv.ct;
            put = 1'b1; put_val = mv.put_val;
         end
         OP_TPEND: begin
            if (b_ff != BYTE_FF) begin
               put = 1'b1; put_val = b_ff; b_in = BYTE_FF;
            end
         end
         OP_TFF: begin
            put = 1'b1; put_val = b_ff; b_in = BYTE_AC;
         end
         OP_TAC: begin
            put = 1'b1; put_val = b_ff; fin_in = 1'b1;
         end
         OP_RELEASE: begin
            rel = 1'b1;
         end
         default: begin
         end
      endcase
      if (put && bfirst_ff) begin
         bfirst_in = 1'b0;
      end
   end

   always_comb begin
      hold_v_in = hold_v_ff; hold_in = hold_ff;
      ov_in = ov_ff && rsp_stall;
      obyte_in = obyte_ff; olast_in = olast_ff; oend_in = oend_ff;
      if (put && !bfirst_ff) begin
         if (hold_v_ff) begin
            ov_in = 1'b1; obyte_in = hold_ff; olast_in = 1'b0; oend_in = 1'b0;
         end
         hold_v_in = 1'b1; hold_in = put_val;
      end
      if (rel && hold_v_ff) begin
         ov_in = 1'b1; obyte_in = hold_ff; olast_in = 1'b1; oend_in = cmd.end_mark;
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= A_INIT; c_ff <= '0; ct_ff <= CT_INIT; b_ff <= '0;
         bfirst_ff <= 1'b1; fin_ff <= 1'b0; renorm_ff <= 1'b0;
         hold_v_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         a_ff <= a_in; c_ff <= c_in; ct_ff <= ct_in; b_ff <= b_in;
         bfirst_ff <= bfirst_in; fin_ff <= fin_in; renorm_ff <= renorm_in;
         hold_v_ff <= hold_v_in; ov_ff <= ov_in;
      end
      ctx_ff <= ctx_in; bit_ff <= bit_in; hold_ff <= hold_in;
      obyte_ff <= obyte_in; olast_ff <= olast_in; oend_ff <= oend_in;
   end

   assign status = '{out_free: out_free, a_msb: a_ff[15], need_renorm: renorm_ff,
                     finished: fin_ff, hold_valid: hold_v_ff};
   assign rsp_valid       = ov_ff;
   assign rsp_code_byte   = obyte_ff;
   assign rsp_last_of_run = olast_ff;
   assign rsp_end_marker  = oend_ff;
endmodule

>>> hw/rtl/mqe_ctrl.sv
// Controller of the MQ encoder: sequences clear, code, renormalization and
// flush steps, and paces them against the output register. Depends on mqe_pkg.
module mqe_ctrl #(
   parameter int CONTEXT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_mode,
   input  mqe_pkg::status_type     status,
   output mqe_pkg::cmd_type        cmd,
   output logic [CONTEXT_BITS-1:0] clear_addr,
   output logic                    idle
);
   import mqe_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_CODE   = 11'b00000000100,
      S_RENORM = 11'b00000001000,
      S_TPREP  = 11'b00000010000,
      S_TMOVE1 = 11'b00000100000,
      S_TMOVE2 = 11'b00001000000,
      S_TPEND  = 11'b00010000000,
      S_TFF    = 11'b00100000000,
      S_TAC    = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CONTEXT_BITS-1:0] addr_ff, addr_in;
   logic [4:0] guard_ff, guard_in;
   logic flush_ff, flush_in;
   logic cont;

   assign cont = (guard_ff == 5'd0) ? status.need_renorm
                                    : (!status.a_msb && (guard_ff < 5'd16));

   always_comb begin
      state_in = state_ff; addr_in = addr_ff; guard_in = guard_ff; flush_in = flush_ff;
      cmd = '{op: OP_NONE, end_mark: flush_ff};
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            addr_in = addr_ff + CONTEXT_BITS'(1);
            if (&addr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_START) begin
                  cmd.op = OP_INIT; state_in = S_CLEAR;
               end else if (req_mode == MODE_ENCODE && !status.finished) begin
                  cmd.op = OP_LOAD; state_in = S_CODE; flush_in = 1'b0;
               end else if (req_mode == MODE_FLUSH && !status.finished) begin
                  state_in = S_TPREP; flush_in = 1'b1;
               end
            end
         end
         S_CODE: begin
            cmd.op = OP_CODE; guard_in = '0; state_in = S_RENORM;
         end
         S_RENORM: begin
            if (!cont) begin
               state_in = S_DONE;
            end else if (status.out_free) begin
               cmd.op = OP_RENORM; guard_in = guard_ff + 5'd1;
            end
         end
         S_TPREP: begin
            cmd.op = OP_TPREP; state_in = S_TMOVE1;
         end
         S_TMOVE1: if (status.out_free) begin
            cmd.op = OP_TMOVE; state_in = S_TMOVE2;
         end
         S_TMOVE2: if (status.out_free) begin
            cmd.op = OP_TMOVE; state_in = S_TPEND;
         end
         S_TPEND: if (status.out_free) begin
            cmd.op = OP_TPEND; state_in = S_TFF;
         end
         S_TFF: if (status.out_free) begin
            cmd.op = OP_TFF; state_in = S_TAC;
         end
         S_TAC: if (status.out_free) begin
            cmd.op = OP_TAC; state_in = S_DONE;
         end
         S_DONE: if (status.out_free) begin
            cmd.op = OP_RELEASE; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; addr_ff <= '0; guard_ff <= '0; flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in; addr_ff <= addr_in; guard_ff <= guard_in;
         flush_ff <= flush_in;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign clear_addr = addr_ff;
   assign idle       = (state_ff == S_IDLE);

   a_code_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_mode == MODE_ENCODE && !status.finished)
      |=> state_ff == S_CODE)
      else $error("encode word did not enter code step");
   a_guard_bound: assert property (@(posedge clock) disable iff (reset)
      guard_ff <= 5'd16)
      else $error("renormalization ran past sixteen shifts");
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && (&addr_ff)) |=> state_ff == S_IDLE)
      else $error("clear sweep did not finish");
endmodule
